>>> src/cpt_pkg.sv
`default_nettype none
package cpt_pkg;

    localparam int CW    = 16;            // coordinate width, signed Q12.4
    localparam int UVW   = 16;            // uv width, unsigned Q1.15
    localparam int FB    = 16;            // fraction bits of the interpolation weights
    localparam int DW    = CW + 1;        // vertex / point difference
    localparam int PW    = 2 * DW;        // one product of a dot
    localparam int DOTW  = PW + 2;        // dot product
    localparam int HW    = DOTW / 2;      // half of a dot product for split multiplies
    localparam int PHW   = 2 * HW;
    localparam int WPW   = 2 * DOTW;      // product of two dots
    localparam int VW    = WPW + 1;       // va, vb, vc
    localparam int DENW  = WPW + 3;       // divider operands
    localparam int TW    = FB + 1;        // weight, 0 .. 1.0

    localparam int CFG_IW = 3;
    localparam int CFG_DW = (3 * CW > 2 * UVW) ? 3 * CW : 2 * UVW;
    localparam int IN_DW  = ((3 * CW + 7) / 8) * 8;
    localparam int OUT_DW = ((3 * CW + 2 * UVW + 7) / 8) * 8;
    localparam int USER_W = 4;

    localparam logic [TW-1:0] T_ONE = {1'b1, {FB{1'b0}}};

    typedef enum logic [CFG_IW-1:0] {
        CFG_VERT_A = CFG_IW'(0),
        CFG_VERT_B = CFG_IW'(1),
        CFG_VERT_C = CFG_IW'(2),
        CFG_UV_A   = CFG_IW'(3),
        CFG_UV_B   = CFG_IW'(4),
        CFG_UV_C   = CFG_IW'(5)
    } t_cfg_idx;

    typedef enum logic [2:0] {
        REG_A  = 3'd0,
        REG_B  = 3'd1,
        REG_AB = 3'd2,
        REG_C  = 3'd3,
        REG_AC = 3'd4,
        REG_BC = 3'd5,
        REG_IN = 3'd6
    } t_region;

    typedef struct packed {
        logic [3*CW-1:0]  va;
        logic [3*CW-1:0]  vb;
        logic [3*CW-1:0]  vc;
        logic [2*UVW-1:0] ua;
        logic [2*UVW-1:0] ub;
        logic [2*UVW-1:0] uc;
    } t_cfg;

    typedef struct packed {
        logic [DENW-1:0] num0;
        logic [DENW-1:0] den0;
        logic [DENW-1:0] num1;
        logic [DENW-1:0] den1;
        t_region         region;
        logic            deg;
    } t_div_in;

    typedef struct packed {
        logic [TW-1:0] q0;
        logic [TW-1:0] q1;
        t_region       region;
        logic          deg;
    } t_div_out;

    typedef struct packed {
        logic [CW-1:0]  nx;
        logic [CW-1:0]  ny;
        logic [CW-1:0]  nz;
        logic [UVW-1:0] tu;
        logic [UVW-1:0] tv;
        t_region        region;
        logic           deg;
    } t_res;

    function automatic logic signed [CW-1:0] f_coord(input logic [3*CW-1:0] r, input int k);
        return $signed(r[k*CW +: CW]);
    endfunction

    function automatic logic [UVW-1:0] f_uv(input logic [2*UVW-1:0] r, input int k);
        return r[k*UVW +: UVW];
    endfunction

endpackage
`default_nettype wire

>>> src/cpt_cfg.sv
`default_nettype none
module cpt_cfg import cpt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    output logic                   o_cfg_ready,
    output t_cfg                   o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VERT_A: r_cfg.va <= i_cfg_data[3*CW-1:0];
                CFG_VERT_B: r_cfg.vb <= i_cfg_data[3*CW-1:0];
                CFG_VERT_C: r_cfg.vc <= i_cfg_data[3*CW-1:0];
                CFG_UV_A:   r_cfg.ua <= i_cfg_data[2*UVW-1:0];
                CFG_UV_B:   r_cfg.ub <= i_cfg_data[2*UVW-1:0];
                CFG_UV_C:   r_cfg.uc <= i_cfg_data[2*UVW-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/cpt_classify.sv
`default_nettype none
module cpt_classify import cpt_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [3*CW-1:0] i_pos,
    input  wire t_cfg            i_cfg,
    output logic                 o_valid,
    output t_div_in              o_div
);

    // operand pairs of the six dot products: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    localparam int PA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int PB [6] = '{3, 1, 1, 5, 5, 3};

    logic signed [CW-1:0] a [3];
    logic signed [CW-1:0] b [3];
    logic signed [CW-1:0] c [3];
    logic signed [DW-1:0] ab [3];
    logic signed [DW-1:0] ac [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i]  = f_coord(i_cfg.va, i);
            b[i]  = f_coord(i_cfg.vb, i);
            c[i]  = f_coord(i_cfg.vc, i);
            ab[i] = DW'(b[i]) - DW'(a[i]);
            ac[i] = DW'(c[i]) - DW'(a[i]);
        end
    end

    logic [7:1] r_v;

    logic signed [DW-1:0]    r1_ap [3];
    logic signed [DW-1:0]    r1_bp [3];
    logic signed [DW-1:0]    r1_cp [3];
    logic signed [PW-1:0]    r2_p [18];
    logic signed [DOTW-1:0]  r3_d [6];
    logic signed [PHW-1:0]   r4_hh [6];
    logic signed [PHW:0]     r4_hl [6];
    logic signed [PHW:0]     r4_lh [6];
    logic [PHW-1:0]          r4_ll [6];
    logic signed [DOTW-1:0]  r4_d [6];
    logic signed [WPW-1:0]   r5_m [6];
    logic signed [DOTW-1:0]  r5_d [6];
    logic signed [VW-1:0]    r6_va, r6_vb, r6_vc;
    logic signed [DOTW-1:0]  r6_d [6];
    t_div_in                 r7_div;

    logic signed [PHW-1:0] n4_hh [6];
    logic signed [PHW:0]   n4_hl [6];
    logic signed [PHW:0]   n4_lh [6];
    logic [PHW-1:0]        n4_ll [6];
    logic signed [WPW-1:0] n5_m [6];
    t_div_in               n7_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    // split multiplies: signed high half, unsigned low half
    always_comb begin
        for (int m = 0; m < 6; m++) begin
            logic signed [HW-1:0] xh, yh;
            logic signed [HW:0]   xl, yl;
            xh = $signed(r3_d[PA[m]][DOTW-1:HW]);
            yh = $signed(r3_d[PB[m]][DOTW-1:HW]);
            xl = $signed({1'b0, r3_d[PA[m]][HW-1:0]});
            yl = $signed({1'b0, r3_d[PB[m]][HW-1:0]});
            n4_hh[m] = PHW'(xh) * PHW'(yh);
            n4_hl[m] = (PHW+1)'(xh) * (PHW+1)'(yl);
            n4_lh[m] = (PHW+1)'(xl) * (PHW+1)'(yh);
            n4_ll[m] = PHW'(r3_d[PA[m]][HW-1:0]) * PHW'(r3_d[PB[m]][HW-1:0]);
        end
    end

    always_comb begin
        for (int m = 0; m < 6; m++) begin
            n5_m[m] = (WPW'(r4_hh[m]) <<< PHW)
                    + ((WPW'(r4_hl[m]) + WPW'(r4_lh[m])) <<< HW)
                    + $signed(WPW'(r4_ll[m]));
        end
    end

    always_comb begin
        logic signed [DENW-1:0] d1, d2, d3, d4, d5, d6, den, e43, e56;
        logic va_le0, vb_le0, vc_le0, den_le0;
        d1 = DENW'(r6_d[0]);
        d2 = DENW'(r6_d[1]);
        d3 = DENW'(r6_d[2]);
        d4 = DENW'(r6_d[3]);
        d5 = DENW'(r6_d[4]);
        d6 = DENW'(r6_d[5]);
        e43 = d4 - d3;
        e56 = d5 - d6;
        den = DENW'(r6_va) + DENW'(r6_vb) + DENW'(r6_vc);
        va_le0  = r6_va[VW-1] | (r6_va == '0);
        vb_le0  = r6_vb[VW-1] | (r6_vb == '0);
        vc_le0  = r6_vc[VW-1] | (r6_vc == '0);
        den_le0 = den[DENW-1] | (den == '0);
        n7_div        = '0;
        n7_div.region = REG_A;
        priority if (d1 <= 0 && d2 <= 0) begin
            n7_div.region = REG_A;
        end else if (d3 >= 0 && d4 <= d3) begin
            n7_div.region = REG_B;
        end else if (vc_le0 && d1 >= 0 && d3 <= 0) begin
            n7_div.region = REG_AB;
            n7_div.num0   = d1;
            n7_div.den0   = d1 - d3;
        end else if (d6 >= 0 && d5 <= d6) begin
            n7_div.region = REG_C;
        end else if (vb_le0 && d2 >= 0 && d6 <= 0) begin
            n7_div.region = REG_AC;
            n7_div.num0   = d2;
            n7_div.den0   = d2 - d6;
        end else if (va_le0 && e43 >= 0 && e56 >= 0) begin
            n7_div.region = REG_BC;
            n7_div.num0   = e43;
            n7_div.den0   = e43 + e56;
        end else if (den_le0) begin
            n7_div.region = REG_A;
            n7_div.deg    = 1'b1;
        end else begin
            n7_div.region = REG_IN;
            n7_div.num0   = DENW'(r6_vb);
            n7_div.den0   = den;
            n7_div.num1   = DENW'(r6_vc);
            n7_div.den1   = den;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_ap[i] <= DW'($signed(i_pos[i*CW +: CW])) - DW'(a[i]);
                r1_bp[i] <= DW'($signed(i_pos[i*CW +: CW])) - DW'(b[i]);
                r1_cp[i] <= DW'($signed(i_pos[i*CW +: CW])) - DW'(c[i]);
                r2_p[i]      <= PW'(ab[i]) * PW'(r1_ap[i]);
                r2_p[3 + i]  <= PW'(ac[i]) * PW'(r1_ap[i]);
                r2_p[6 + i]  <= PW'(ab[i]) * PW'(r1_bp[i]);
                r2_p[9 + i]  <= PW'(ac[i]) * PW'(r1_bp[i]);
                r2_p[12 + i] <= PW'(ab[i]) * PW'(r1_cp[i]);
                r2_p[15 + i] <= PW'(ac[i]) * PW'(r1_cp[i]);
            end
            for (int k = 0; k < 6; k++) begin
                r3_d[k] <= DOTW'(r2_p[3*k]) + DOTW'(r2_p[3*k + 1]) + DOTW'(r2_p[3*k + 2]);
                r4_hh[k] <= n4_hh[k];
                r4_hl[k] <= n4_hl[k];
                r4_lh[k] <= n4_lh[k];
                r4_ll[k] <= n4_ll[k];
                r4_d[k]  <= r3_d[k];
                r5_m[k]  <= n5_m[k];
                r5_d[k]  <= r4_d[k];
                r6_d[k]  <= r5_d[k];
            end
            r6_vc  <= VW'(r5_m[0]) - VW'(r5_m[1]);
            r6_vb  <= VW'(r5_m[2]) - VW'(r5_m[3]);
            r6_va  <= VW'(r5_m[4]) - VW'(r5_m[5]);
            r7_div <= n7_div;
        end
    end

    assign o_valid = r_v[7];
    assign o_div   = r7_div;

endmodule
`default_nettype wire

>>> src/cpt_div.sv
`default_nettype none
module cpt_div import cpt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire logic    i_valid,
    input  wire t_div_in i_d,
    output logic         o_valid,
    output t_div_out     o_q
);

    typedef struct packed {
        logic [DENW-1:0] rem;
        logic [DENW-1:0] den;
        logic [FB-1:0]   q;
        logic            fz;   // result forced to zero
        logic            fo;   // result forced to one
    } t_dlane;

    function automatic t_dlane f_init(input logic [DENW-1:0] num, input logic [DENW-1:0] den);
        t_dlane l;
        l.rem = num;
        l.den = den;
        l.q   = '0;
        l.fz  = den[DENW-1] | (den == '0) | num[DENW-1];
        l.fo  = !l.fz && !($signed(num) < $signed(den));
        return l;
    endfunction

    // one quotient bit, restoring
    function automatic t_dlane f_step(input t_dlane l);
        logic [DENW-1:0] r2;
        t_dlane o;
        o  = l;
        r2 = {l.rem[DENW-2:0], 1'b0};
        o.q = {l.q[FB-2:0], 1'b0};
        if (r2 >= l.den) begin
            o.rem  = r2 - l.den;
            o.q[0] = 1'b1;
        end else begin
            o.rem = r2;
        end
        return o;
    endfunction

    function automatic logic [TW-1:0] f_fin(input t_dlane l);
        if (l.fz) return '0;
        if (l.fo) return T_ONE;
        return {1'b0, l.q};
    endfunction

    logic    r_v   [FB+1];
    t_dlane  r_l0  [FB+1];
    t_dlane  r_l1  [FB+1];
    t_region r_reg [FB+1];
    logic    r_deg [FB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FB; k++) r_v[k] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= FB; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l0[0]  <= f_init(i_d.num0, i_d.den0);
            r_l1[0]  <= f_init(i_d.num1, i_d.den1);
            r_reg[0] <= i_d.region;
            r_deg[0] <= i_d.deg;
            for (int k = 1; k <= FB; k++) begin
                r_l0[k]  <= f_step(r_l0[k-1]);
                r_l1[k]  <= f_step(r_l1[k-1]);
                r_reg[k] <= r_reg[k-1];
                r_deg[k] <= r_deg[k-1];
            end
        end
    end

    assign o_valid    = r_v[FB];
    assign o_q.q0     = f_fin(r_l0[FB]);
    assign o_q.q1     = f_fin(r_l1[FB]);
    assign o_q.region = r_reg[FB];
    assign o_q.deg    = r_deg[FB];

endmodule
`default_nettype wire

>>> src/cpt_interp.sv
`default_nettype none
module cpt_interp import cpt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_div_out i_q,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_m_ready,
    output logic          o_en,
    output logic          o_valid,
    output t_res          o_res
);

    localparam int PXW  = DW + TW + 2;
    localparam int UPW  = UVW + TW;
    localparam int UPW2 = UPW + 2;
    localparam logic signed [PXW-1:0] SMAX = $signed({{(PXW-CW+1){1'b0}}, {(CW-1){1'b1}}});
    localparam logic signed [PXW-1:0] SMIN = ~SMAX;
    localparam logic [FB-1:0] HALF = {1'b1, {(FB-1){1'b0}}};

    logic en;

    logic                 r1_v, r2_v;
    logic signed [CW-1:0] r1_base [3];
    logic signed [DW-1:0] r1_e1 [3];
    logic signed [DW-1:0] r1_e2 [3];
    logic [TW-1:0]        r1_s1, r1_s2, r1_ka, r1_kb, r1_kc;
    t_region              r1_reg, r2_reg;
    logic                 r1_deg, r2_deg;
    logic signed [CW-1:0] r2_base [3];
    logic signed [PXW-1:0] r2_pe1 [3];
    logic signed [PXW-1:0] r2_pe2 [3];
    logic [UPW-1:0]       r2_pu [2][3];
    logic                 r_ov, r_skid_v;
    t_res                 r_out, r_skid;

    logic signed [CW-1:0] n1_base [3];
    logic signed [DW-1:0] n1_e1 [3];
    logic signed [DW-1:0] n1_e2 [3];
    logic [TW-1:0]        n1_s1, n1_s2, n1_ka, n1_kb, n1_kc;
    t_res                 res;

    assign en = !r_skid_v;

    always_comb begin
        logic signed [DW-1:0] ab [3], ac [3], bc [3];
        logic signed [CW-1:0] a [3], b [3], c [3];
        logic [TW:0]          vw;
        logic [TW-1:0]        v, w, u, t;
        for (int i = 0; i < 3; i++) begin
            a[i]  = f_coord(i_cfg.va, i);
            b[i]  = f_coord(i_cfg.vb, i);
            c[i]  = f_coord(i_cfg.vc, i);
            ab[i] = DW'(b[i]) - DW'(a[i]);
            ac[i] = DW'(c[i]) - DW'(a[i]);
            bc[i] = DW'(c[i]) - DW'(b[i]);
        end
        t  = i_q.q0;
        v  = i_q.q0;
        vw = {1'b0, i_q.q0} + {1'b0, i_q.q1};
        w  = (vw > {1'b0, T_ONE}) ? T_ONE - i_q.q0 : i_q.q1;
        u  = T_ONE - v - w;
        n1_base = a;
        n1_e1   = ab;
        n1_e2   = ac;
        n1_s1   = '0;
        n1_s2   = '0;
        n1_ka   = '0;
        n1_kb   = '0;
        n1_kc   = '0;
        unique case (i_q.region)
            REG_B: begin
                n1_base = b;
                n1_kb   = T_ONE;
            end
            REG_AB: begin
                n1_s1 = t;
                n1_ka = T_ONE - t;
                n1_kb = t;
            end
            REG_C: begin
                n1_base = c;
                n1_kc   = T_ONE;
            end
            REG_AC: begin
                n1_e1 = ac;
                n1_s1 = t;
                n1_ka = T_ONE - t;
                n1_kc = t;
            end
            REG_BC: begin
                n1_base = b;
                n1_e1   = bc;
                n1_s1   = t;
                n1_kb   = T_ONE - t;
                n1_kc   = t;
            end
            REG_IN: begin
                n1_s1 = v;
                n1_s2 = w;
                n1_ka = u;
                n1_kb = v;
                n1_kc = w;
            end
            default: begin
                n1_ka = T_ONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_base <= n1_base;
            r1_e1   <= n1_e1;
            r1_e2   <= n1_e2;
            r1_s1   <= n1_s1;
            r1_s2   <= n1_s2;
            r1_ka   <= n1_ka;
            r1_kb   <= n1_kb;
            r1_kc   <= n1_kc;
            r1_reg  <= i_q.region;
            r1_deg  <= i_q.deg;
            for (int i = 0; i < 3; i++) begin
                r2_pe1[i] <= PXW'(r1_e1[i]) * $signed(PXW'(r1_s1));
                r2_pe2[i] <= PXW'(r1_e2[i]) * $signed(PXW'(r1_s2));
            end
            for (int j = 0; j < 2; j++) begin
                r2_pu[j][0] <= UPW'(f_uv(i_cfg.ua, j)) * UPW'(r1_ka);
                r2_pu[j][1] <= UPW'(f_uv(i_cfg.ub, j)) * UPW'(r1_kb);
                r2_pu[j][2] <= UPW'(f_uv(i_cfg.uc, j)) * UPW'(r1_kc);
            end
            r2_base <= r1_base;
            r2_reg  <= r1_reg;
            r2_deg  <= r1_deg;
        end
    end

    // round, add base, saturate the coordinates; round the UV
    always_comb begin
        logic signed [PXW-1:0] s, tot;
        logic [UPW2-1:0]       us;
        logic [CW-1:0]         n [3];
        logic [UVW-1:0]        uvo [2];
        for (int i = 0; i < 3; i++) begin
            s   = r2_pe1[i] + r2_pe2[i] + $signed(PXW'(HALF));
            tot = (s >>> FB) + PXW'(r2_base[i]);
            if (tot > SMAX) begin
                n[i] = SMAX[CW-1:0];
            end else if (tot < SMIN) begin
                n[i] = SMIN[CW-1:0];
            end else begin
                n[i] = tot[CW-1:0];
            end
        end
        for (int j = 0; j < 2; j++) begin
            us = UPW2'(r2_pu[j][0]) + UPW2'(r2_pu[j][1]) + UPW2'(r2_pu[j][2]) + UPW2'(HALF);
            uvo[j] = us[FB +: UVW];
        end
        res.nx     = n[0];
        res.ny     = n[1];
        res.nz     = n[2];
        res.tu     = uvo[0];
        res.tv     = uvo[1];
        res.region = r2_reg;
        res.deg    = r2_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (en) begin
                r1_v <= i_valid;
                r2_v <= r1_v;
            end
            if (!r_ov || i_m_ready) begin
                if (r_skid_v) begin
                    r_ov     <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_ov <= r2_v;
                end
            end else if (r2_v && !r_skid_v) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || i_m_ready) begin
            r_out <= r_skid_v ? r_skid : res;
        end else if (!r_skid_v) begin
            r_skid <= res;
        end
    end

    assign o_en    = en;
    assign o_valid = r_ov;
    assign o_res   = r_out;

endmodule
`default_nettype wire

>>> src/closest_point_on_triangle_uv.sv
// Closest point on a configured triangle, with interpolated UV.
// Config: write vert_a/b/c (index 0..2) and uv_a/b/c (index 3..5) on the
// cfg channel (always ready) while no item is in flight; all reset to 0.
// Input stream s_axis: one query point per item (x, y, z, signed Q12.4).
// Output stream m_axis: closest point and UV in tdata, region code and the
// degenerate-triangle flag in tuser.
// Pipeline: 7 classify stages, 17 divider stages, 2 interpolation stages
// and the output register lie between input acceptance and m_axis_tvalid.
// Throughput: one item per cycle while the pipeline is not held; in each
// divider stage after the first, the two divider lanes produce one quotient bit.
// Stalls: the output register has a one-item skid buffer behind it. While
// the skid buffer is empty the whole pipeline advances and s_axis_tready
// is high, so items are accepted while a result waits; once it fills, the
// pipeline holds and s_axis_tready drops until m_axis_tready frees it.
// Reset (i_rst_n low, synchronous) clears all valid bits and the
// configuration registers; the data registers are left as they are.
`default_nettype none
module closest_point_on_triangle_uv import cpt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_DW-1:0]  s_axis_tdata,   // pos_x, pos_y, pos_z
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [OUT_DW-1:0]      m_axis_tdata,   // near_x, near_y, near_z, tex_u, tex_v
    output logic [USER_W-1:0]      m_axis_tuser    // region[2:0], degenerate
);

    t_cfg     cfg;
    logic     en;
    logic     cls_v, div_v;
    t_div_in  cls_d;
    t_div_out div_q;
    t_res     res;

    cpt_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    cpt_classify u_cls (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s_axis_tvalid),
        .i_pos   (s_axis_tdata[3*CW-1:0]),
        .i_cfg   (cfg),
        .o_valid (cls_v),
        .o_div   (cls_d)
    );

    cpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (cls_v),
        .i_d     (cls_d),
        .o_valid (div_v),
        .o_q     (div_q)
    );

    cpt_interp u_int (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (div_v),
        .i_q       (div_q),
        .i_cfg     (cfg),
        .i_m_ready (m_axis_tready),
        .o_en      (en),
        .o_valid   (m_axis_tvalid),
        .o_res     (res)
    );

    assign s_axis_tready = en;
    assign m_axis_tdata  = OUT_DW'({res.tv, res.tu, res.nz, res.ny, res.nx});
    assign m_axis_tuser  = {res.deg, res.region};

endmodule
`default_nettype wire
